>>> rtl/xper_pkg.sv
// Shared constants, codes and types of the XOR parity erasure recovery block.
`default_nettype none
package xper_pkg;

    localparam int MAX_SYMBOL_BYTES_DEF   = 2048;
    localparam int MAX_SOURCE_SYMBOLS_DEF = 64;

    localparam int FUNC_W = 3;
    localparam int IDX_W  = 6;
    localparam int OFF_W  = 11;
    localparam int BYTE_W = 8;
    localparam int TOT_W  = 7;
    localparam int LEN_W  = 12;

    typedef enum logic [FUNC_W-1:0] {
        FN_REPAIR = 3'd0,
        FN_SOURCE = 3'd1,
        FN_EVAL   = 3'd2,
        FN_READ   = 3'd3,
        FN_NEW    = 3'd4
    } func_t;

    localparam logic ANS_EVAL = 1'b0;
    localparam logic ANS_READ = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic done;
        logic ok;
    } scan_stat_t;

endpackage
`default_nettype wire

>>> rtl/xper_ram.sv
// Recovery buffer: byte-wide single-port-write, registered-read memory.
`default_nettype none
module xper_ram #(
    parameter int DEPTH = xper_pkg::MAX_SYMBOL_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [xper_pkg::BYTE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [xper_pkg::BYTE_W-1:0] rdata
);
    import xper_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/xper_scan.sv
// Evaluate unit: walks the presence map one index per cycle, counts absent entries.
`default_nettype none
module xper_scan #(
    parameter int MAX_SOURCE_SYMBOLS = xper_pkg::MAX_SOURCE_SYMBOLS_DEF,
    parameter int SW = $clog2(MAX_SOURCE_SYMBOLS),
    parameter int CW = $clog2(MAX_SOURCE_SYMBOLS + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [CW-1:0]                 total,
    input  wire logic [MAX_SOURCE_SYMBOLS-1:0] pres,
    output xper_pkg::scan_stat_t               stat,
    output logic      [SW-1:0]                 miss
);
    import xper_pkg::*;

    logic          busy_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] total_reg;
    logic [1:0]    absent_reg;
    logic [SW-1:0] miss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            absent_reg <= 2'd0;
        end else if (start) begin
            busy_reg   <= 1'b1;
            idx_reg    <= '0;
            total_reg  <= total;
            absent_reg <= 2'd0;
        end else if (busy_reg) begin
            if (idx_reg == total_reg) begin
                busy_reg <= 1'b0;
            end else begin
                if (!pres[idx_reg[SW-1:0]]) begin
                    absent_reg <= (absent_reg == 2'd2) ? 2'd2 : absent_reg + 2'd1;
                    miss_reg   <= idx_reg[SW-1:0];
                end
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    assign stat.done = busy_reg && (idx_reg == total_reg);
    assign stat.ok   = (absent_reg == 2'd1);
    assign miss      = miss_reg;

endmodule
`default_nettype wire

>>> rtl/xor_parity_erasure_recovery.sv
// Top level: XOR parity single-erasure recovery with buffer RMW, evaluate and readback.
// Repair and source bytes are XORed into an on-chip recovery buffer by a
// read-modify-write pipeline with forwarding, so byte transactions are taken one per
// cycle while s_ready is high. A read transaction passes through st1_rd_reg into the
// result register, which raises m_valid; input is held off while st1_rd_reg is set.
// Evaluate walks the presence map one index per cycle, holds off input until it
// answers, and walks no entries when the repair count is not one or total_source exceeds
// MAX_SOURCE_SYMBOLS. Read and evaluate transactions also wait while a result is pending
// on the output. After reset and after each start-new-block transaction the buffer
// is zeroed one byte per cycle, all MAX_SYMBOL_BYTES bytes, with s_ready low.
// Bytes at offsets >= MAX_SYMBOL_BYTES and source indexes >= MAX_SOURCE_SYMBOLS are
// dropped; more bytes for a source already marked present are dropped.
`default_nettype none
module xor_parity_erasure_recovery #(
    parameter int MAX_SYMBOL_BYTES   = xper_pkg::MAX_SYMBOL_BYTES_DEF,
    parameter int MAX_SOURCE_SYMBOLS = xper_pkg::MAX_SOURCE_SYMBOLS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [xper_pkg::FUNC_W-1:0]   s_func,
    input  wire logic [xper_pkg::IDX_W-1:0]    s_symbol_index,
    input  wire logic [xper_pkg::OFF_W-1:0]    s_byte_offset,
    input  wire logic [xper_pkg::BYTE_W-1:0]   s_data_byte,
    input  wire logic                          s_last_byte,
    input  wire logic [xper_pkg::TOT_W-1:0]    s_total_source,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_answer_kind,
    output logic                               m_status,
    output logic      [xper_pkg::IDX_W-1:0]    m_missing_index,
    output logic      [xper_pkg::LEN_W-1:0]    m_symbol_length,
    output logic      [xper_pkg::BYTE_W-1:0]   m_read_byte
);
    import xper_pkg::*;

    localparam int AW = $clog2(MAX_SYMBOL_BYTES);
    localparam int XW = ((AW > OFF_W) ? AW : OFF_W) + 1;
    localparam int SW = $clog2(MAX_SOURCE_SYMBOLS);
    localparam int IW = ((SW > IDX_W) ? SW : IDX_W) + 1;
    localparam int CW = $clog2(MAX_SOURCE_SYMBOLS + 1);
    localparam int TW = ((CW > TOT_W) ? CW : TOT_W) + 1;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic          clearing;
    logic          clr_last;

    logic [MAX_SOURCE_SYMBOLS-1:0] pres_reg;
    logic [1:0]      rcnt_reg;
    logic [LEN_W-1:0] rlen_reg;
    logic            recovered_reg;
    logic [SW-1:0]   rec_idx_reg;

    logic            st1_wr_reg;
    logic            st1_rd_reg;
    logic            st1_use_mem_reg;
    logic [AW-1:0]   st1_addr_reg;
    logic [BYTE_W-1:0] st1_data_reg;

    logic            fwd_valid_reg;
    logic [AW-1:0]   fwd_addr_reg;
    logic [BYTE_W-1:0] fwd_data_reg;

    logic            m_valid_reg;
    logic            m_kind_reg;
    logic            m_status_reg;
    logic [IDX_W-1:0] m_miss_reg;
    logic [LEN_W-1:0] m_len_reg;
    logic [BYTE_W-1:0] m_byte_reg;

    logic [XW-1:0]   off_x;
    logic            off_ok;
    logic [IW-1:0]   idx_x;
    logic            idx_ok;
    logic [SW-1:0]   idx_sel;
    logic [TW-1:0]   tot_x;
    logic            tot_ok;
    logic            acc;
    logic            needs_out;
    logic            src_ok;
    logic            xor_en;
    logic            rd_ok;
    logic            ram_re;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] merged;
    logic            st1_wr_fire;
    logic            scan_start;
    logic [CW-1:0]   scan_total;
    scan_stat_t      scan_stat;
    logic [SW-1:0]   scan_miss;

    assign off_x   = XW'(s_byte_offset);
    assign off_ok  = off_x < XW'(MAX_SYMBOL_BYTES);
    assign idx_x   = IW'(s_symbol_index);
    assign idx_ok  = idx_x < IW'(MAX_SOURCE_SYMBOLS);
    assign idx_sel = idx_x[SW-1:0];
    assign tot_x   = TW'(s_total_source);
    assign tot_ok  = tot_x <= TW'(MAX_SOURCE_SYMBOLS);

    assign clearing = (state_reg == ST_CLEAR);
    assign clr_last = (clr_reg == AW'(MAX_SYMBOL_BYTES - 1));

    assign needs_out = (s_func == FN_EVAL) || (s_func == FN_READ);
    assign s_ready   = (state_reg == ST_RUN) && !st1_rd_reg
                       && !(needs_out && m_valid_reg && !m_ready);
    assign acc       = s_valid && s_ready;

    assign src_ok = (s_func == FN_SOURCE) && off_ok && idx_ok && !pres_reg[idx_sel];
    assign xor_en = ((s_func == FN_REPAIR) && off_ok) || src_ok;
    assign rd_ok  = recovered_reg && off_ok && (off_x < XW'(rlen_reg));
    assign ram_re = acc && (xor_en || (s_func == FN_READ));

    assign merged      = (fwd_valid_reg && (fwd_addr_reg == st1_addr_reg))
                         ? fwd_data_reg : ram_rdata;
    assign st1_wr_fire = st1_wr_reg && !clearing;
    assign ram_we      = clearing || st1_wr_fire;
    assign ram_waddr   = clearing ? clr_reg : st1_addr_reg;
    assign ram_wdata   = clearing ? '0 : (merged ^ st1_data_reg);

    assign scan_start = acc && (s_func == FN_EVAL);
    assign scan_total = ((rcnt_reg == 2'd1) && tot_ok) ? CW'(tot_x) : '0;

    xper_ram #(
        .DEPTH (MAX_SYMBOL_BYTES),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (off_x[AW-1:0]),
        .rdata (ram_rdata)
    );

    xper_scan #(
        .MAX_SOURCE_SYMBOLS (MAX_SOURCE_SYMBOLS),
        .SW                 (SW),
        .CW                 (CW)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .total   (scan_total),
        .pres    (pres_reg),
        .stat    (scan_stat),
        .miss    (scan_miss)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (acc && (s_func == FN_NEW)) begin
                    state_next = ST_CLEAR;
                end else if (scan_start) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (scan_stat.done) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // block state: presence map, counters, recovered symbol
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            pres_reg      <= '0;
            rcnt_reg      <= 2'd0;
            rlen_reg      <= '0;
            recovered_reg <= 1'b0;
            rec_idx_reg   <= '0;
        end else begin
            if (clearing) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (acc) begin
                if (s_func == FN_NEW) begin
                    clr_reg       <= '0;
                    pres_reg      <= '0;
                    rcnt_reg      <= 2'd0;
                    rlen_reg      <= '0;
                    recovered_reg <= 1'b0;
                    rec_idx_reg   <= '0;
                end else if ((s_func == FN_REPAIR) && off_ok && s_last_byte) begin
                    rlen_reg <= LEN_W'(off_x + XW'(1));
                    if (rcnt_reg != 2'd3) begin
                        rcnt_reg <= rcnt_reg + 2'd1;
                    end
                end else if (src_ok && s_last_byte) begin
                    pres_reg[idx_sel] <= 1'b1;
                end
            end
            if (scan_stat.done && scan_stat.ok) begin
                pres_reg[scan_miss] <= 1'b1;
                recovered_reg       <= 1'b1;
                rec_idx_reg         <= scan_miss;
            end
        end
    end

    // buffer read-modify-write stage with one-deep write forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_wr_reg    <= 1'b0;
            st1_rd_reg    <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            st1_wr_reg    <= acc && xor_en;
            st1_rd_reg    <= acc && (s_func == FN_READ);
            fwd_valid_reg <= st1_wr_fire;
        end
        if (acc) begin
            st1_addr_reg    <= off_x[AW-1:0];
            st1_data_reg    <= s_data_byte;
            st1_use_mem_reg <= rd_ok;
        end
        if (st1_wr_fire) begin
            fwd_addr_reg <= st1_addr_reg;
            fwd_data_reg <= ram_wdata;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st1_rd_reg || scan_stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (st1_rd_reg) begin
            m_kind_reg   <= ANS_READ;
            m_status_reg <= recovered_reg ? STAT_OK : STAT_FAIL;
            m_miss_reg   <= recovered_reg ? IDX_W'(rec_idx_reg) : '0;
            m_len_reg    <= recovered_reg ? rlen_reg : '0;
            m_byte_reg   <= st1_use_mem_reg ? merged : '0;
        end else if (scan_stat.done) begin
            m_kind_reg   <= ANS_EVAL;
            m_status_reg <= scan_stat.ok ? STAT_OK : STAT_FAIL;
            m_miss_reg   <= scan_stat.ok ? IDX_W'(scan_miss) : '0;
            m_len_reg    <= scan_stat.ok ? rlen_reg : '0;
            m_byte_reg   <= '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_answer_kind   = m_kind_reg;
    assign m_status        = m_status_reg;
    assign m_missing_index = m_miss_reg;
    assign m_symbol_length = m_len_reg;
    assign m_read_byte     = m_byte_reg;

    a_new_block_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && (s_func == FN_NEW)) |=> !s_ready)
        else $error("input taken during buffer clear");

    a_one_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !(st1_rd_reg && scan_stat.done))
        else $error("read and evaluate answers collide");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_rd_reg || scan_stat.done) |-> (!m_valid_reg || m_ready))
        else $error("pending transaction overwritten");

    a_success_recorded: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_stat.done && scan_stat.ok) |=> (recovered_reg && m_valid_reg
                                             && (m_status_reg == STAT_OK)))
        else $error("recovery not recorded");

endmodule
`default_nettype wire
